FILE: hdl/smx2d_pkg.sv
// Shared constants, permutation table and gradient helpers for the 2D simplex noise unit.
`timescale 1ns / 1ps

package smx2d_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;

	// hash is only observed through one byte of its 24-bit mix; all 37 bits of the sum feed that byte
	localparam int HASH_W = 37;
	localparam int MIX_W  = 24;

	localparam logic [HASH_W-1:0] HASH_CX = HASH_W'(64'h165667B5);
	localparam logic [HASH_W-1:0] HASH_CY = HASH_W'(64'h27D4EB2B);
	localparam logic [HASH_W-1:0] HASH_CS = HASH_W'(64'h48FC803B);
	localparam logic [MIX_W-1:0]  HASH_CM = MIX_W'(64'h4BF19F5D);

	localparam logic signed [30:0] SKEW_Q30   = 31'sd393016785;
	localparam logic [27:0]        UNSKEW_Q30 = 28'd226908346;
	localparam logic signed [31:0] Q30_ONE    = 32'sd1073741824;
	localparam logic signed [35:0] Q30_HALF   = 36'sd536870912;

	// number of pipeline stages inside the corner unit
	localparam int CORNER_STAGES = 5;

	localparam logic [7:0] PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
		8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
		8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
		8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
		8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
		8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
		8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
		8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
		8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
		8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
		8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
		8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
		8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
		8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
		8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
		8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
		8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
		8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
		8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
		8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	function automatic logic signed [32:0] grad_dot(input logic [3:0] h,
		input logic signed [31:0] dx, input logic signed [31:0] dy);
		logic signed [32:0] u;
		logic signed [32:0] v;
		u = (h < 4'd8) ? 33'(dx) : 33'(dy);
		if (h < 4'd4)
			v = 33'(dy);
		else if (h == 4'd12 || h == 4'd14)
			v = 33'(dx);
		else
			v = '0;
		if (h[0])
			u = -u;
		if (h[1])
			v = -v;
		return u + v;
	endfunction

endpackage

FILE: hdl/smx2d_corner.sv
// Pipelined contribution of one simplex corner: falloff, hash mix, gradient, product.
`timescale 1ns / 1ps

module smx2d_corner (
	input  logic                                      clk,
	input  logic [smx2d_pkg::CORNER_STAGES-1:0]       en,
	input  logic signed [31:0]                        dx,
	input  logic signed [31:0]                        dy,
	input  logic [smx2d_pkg::HASH_W-1:0]              hsh,
	output logic signed [31:0]                        contrib
);

	logic [32:0]                     sqx_s1, sqy_s1;
	logic [smx2d_pkg::MIX_W-1:0]     mix_s1;
	logic signed [31:0]              dx_s1, dy_s1;
	logic signed [63:0]              px, py;

	logic signed [35:0]              t_s2;
	logic [smx2d_pkg::MIX_W-1:0]     p_s2;
	logic signed [31:0]              dx_s2, dy_s2;

	logic [28:0]                     t2_s3;
	logic signed [32:0]              g_s3;
	logic                            tpos_s3;
	logic [59:0]                     tt;
	logic [7:0]                      hv;
	logic [7:0]                      pv;

	logic [26:0]                     t4_s4;
	logic signed [32:0]              g_s4;
	logic                            tpos_s4;
	logic [57:0]                     t22;

	logic signed [60:0]              tg;

	assign px = 64'(dx) * 64'(dx);
	assign py = 64'(dy) * 64'(dy);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sqx_s1 <= px[62:30];
			sqy_s1 <= py[62:30];
			mix_s1 <= hsh[smx2d_pkg::MIX_W-1:0] ^ hsh[smx2d_pkg::HASH_W-1:13];
			dx_s1  <= dx;
			dy_s1  <= dy;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s2  <= smx2d_pkg::Q30_HALF - $signed({3'b0, sqx_s1}) - $signed({3'b0, sqy_s1});
			p_s2  <= mix_s1 * smx2d_pkg::HASH_CM;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
		end
	end

	assign tt = t_s2[29:0] * t_s2[29:0];
	assign hv = p_s2[7:0] ^ p_s2[23:16];
	assign pv = smx2d_pkg::PERM[hv];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t2_s3   <= tt[58:30];
			g_s3    <= smx2d_pkg::grad_dot(pv[3:0], dx_s2, dy_s2);
			tpos_s3 <= (t_s2 > 36'sd0);
		end
	end

	assign t22 = t2_s3 * t2_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			t4_s4   <= t22[56:30];
			g_s4    <= g_s3;
			tpos_s4 <= tpos_s3;
		end
	end

	assign tg = $signed({34'b0, t4_s4}) * 61'(g_s4);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			contrib <= tpos_s4 ? 32'($signed(tg[60:30])) : '0;
		end
	end

endmodule

FILE: hdl/simplex_noise_2d_unit.sv
// Top level of the 2D simplex noise unit: skew, cell search, corner hashing and output scaling.
`timescale 1ns / 1ps

// One 2D simplex noise sample per transfer.
// Input stream s_axis: tdata carries coord_x, coord_y (signed, COORD_FRAC_BITS
// fraction bits) and the 32-bit seed. Output stream m_axis: tdata carries the
// signed Q1.15 noise value, saturated to plus or minus one.
// Every input transfer yields exactly one output transfer, in order.
// Throughput: one sample per cycle while m_axis_tready is high; the
// pipeline is 13 register stages, set by the chain of dependent multiplies
// (skew, unskew, square, t^2, t^4, gradient).
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and s_axis_tready stays high while any stage is empty, even
// when the receiver holds m_axis_tready low. A stall loses no sample.
// Reset (arst_n low) empties the pipeline; no output is valid afterwards
// until new samples arrive. There is no configuration and no state between
// samples.
module simplex_noise_2d_unit #(
	parameter int COORD_FRAC_BITS = smx2d_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // coord_x[31:0], coord_y[63:32], seed[95:64]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // noise_value[15:0]
);

	localparam int NSTG = 13;
	localparam int SH   = COORD_FRAC_BITS + 30;
	localparam int IW   = 64 - SH;
	localparam int HW   = smx2d_pkg::HASH_W;
	localparam int CS   = smx2d_pkg::CORNER_STAGES;

	logic [NSTG:1] vld_q;
	logic [NSTG:1] rdy;

	always_comb begin
		rdy[NSTG] = ~vld_q[NSTG] | m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--)
			rdy[k] = ~vld_q[k] | rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1])
				vld_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= NSTG; k++)
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld_q[NSTG];

	// stage 1
	logic signed [31:0] x_s1, y_s1, seed_s1;
	logic signed [32:0] sxy_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			x_s1    <= s_axis_tdata[31:0];
			y_s1    <= s_axis_tdata[63:32];
			seed_s1 <= s_axis_tdata[95:64];
			sxy_s1  <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
				+ $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
		end
	end

	// stage 2: skew product, seed hash term
	logic signed [31:0] x_s2, y_s2;
	logic signed [63:0] skew_s2;
	logic [HW-1:0]      hs_s2;
	logic signed [63:0] skew_d;
	logic [HW-1:0]      seed_e;

	assign skew_d = sxy_s1 * smx2d_pkg::SKEW_Q30;
	assign seed_e = HW'(seed_s1);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			skew_s2 <= skew_d;
			hs_s2   <= seed_e * smx2d_pkg::HASH_CS;
		end
	end

	// stage 3: skewed coordinates, cell and fraction
	logic signed [IW-1:0] i_s3, j_s3;
	logic [29:0]          fx_s3, fy_s3;
	logic [HW-1:0]        hs_s3;
	logic signed [63:0]   xs, ys;

	assign xs = $signed({{2{x_s2[31]}}, x_s2, 30'b0}) + skew_s2;
	assign ys = $signed({{2{y_s2[31]}}, y_s2, 30'b0}) + skew_s2;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			i_s3  <= xs[63:SH];
			j_s3  <= ys[63:SH];
			fx_s3 <= xs[SH-1:COORD_FRAC_BITS];
			fy_s3 <= ys[SH-1:COORD_FRAC_BITS];
			hs_s3 <= hs_s2;
		end
	end

	// stage 4: unskew product, cell hash terms
	logic [28:0]   back_s4;
	logic [29:0]   fx_s4, fy_s4;
	logic [HW-1:0] ha_s4, hb_s4, hs_s4;
	logic [58:0]   back_d;
	logic [HW-1:0] i_e, j_e;

	assign back_d = ({1'b0, fx_s3} + {1'b0, fy_s3}) * smx2d_pkg::UNSKEW_Q30;
	assign i_e    = HW'(i_s3);
	assign j_e    = HW'(j_s3);

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			back_s4 <= back_d[58:30];
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
			ha_s4   <= i_e * smx2d_pkg::HASH_CX;
			hb_s4   <= j_e * smx2d_pkg::HASH_CY;
			hs_s4   <= hs_s3;
		end
	end

	// stage 5: first corner offsets, middle corner choice, base hash
	logic signed [31:0] x0_s5, y0_s5;
	logic               i1_s5;
	logic [HW-1:0]      h0_s5;
	logic signed [31:0] x0_d, y0_d;

	assign x0_d = $signed({2'b0, fx_s4}) - $signed({3'b0, back_s4});
	assign y0_d = $signed({2'b0, fy_s4}) - $signed({3'b0, back_s4});

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			x0_s5 <= x0_d;
			y0_s5 <= y0_d;
			i1_s5 <= (x0_d > y0_d);
			h0_s5 <= ha_s4 + hb_s4 + hs_s4;
		end
	end

	// stage 6: offsets and hashes of all three corners
	logic signed [31:0] dx_s6 [3];
	logic signed [31:0] dy_s6 [3];
	logic [HW-1:0]      h_s6  [3];
	logic signed [31:0] g2;

	assign g2 = 32'(smx2d_pkg::UNSKEW_Q30);

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			dx_s6[0] <= x0_s5;
			dy_s6[0] <= y0_s5;
			h_s6[0]  <= h0_s5;
			dx_s6[1] <= x0_s5 - (i1_s5 ? smx2d_pkg::Q30_ONE : 32'sd0) + g2;
			dy_s6[1] <= y0_s5 - (i1_s5 ? 32'sd0 : smx2d_pkg::Q30_ONE) + g2;
			h_s6[1]  <= h0_s5 + (i1_s5 ? smx2d_pkg::HASH_CX : smx2d_pkg::HASH_CY);
			dx_s6[2] <= x0_s5 - smx2d_pkg::Q30_ONE + g2 + g2;
			dy_s6[2] <= y0_s5 - smx2d_pkg::Q30_ONE + g2 + g2;
			h_s6[2]  <= h0_s5 + smx2d_pkg::HASH_CX + smx2d_pkg::HASH_CY;
		end
	end

	// stages 7 to 11: corner units
	logic signed [31:0] ctb [3];

	for (genvar c = 0; c < 3; c++) begin : g_corner
		smx2d_corner u_corner (
			.clk     (clk),
			.en      (rdy[11:7]),
			.dx      (dx_s6[c]),
			.dy      (dy_s6[c]),
			.hsh     (h_s6[c]),
			.contrib (ctb[c])
		);
	end

	// stage 12: sum
	logic signed [33:0] sum_s12;

	always_ff @(posedge clk) begin
		if (rdy[12]) begin
			sum_s12 <= 34'(ctb[0]) + 34'(ctb[1]) + 34'(ctb[2]);
		end
	end

	// stage 13: scale, round, saturate
	logic signed [40:0] scl;
	logic signed [25:0] rnd;

	assign scl = 41'(sum_s12) * 41'sd70 + 41'sd16384;
	assign rnd = scl[40:15];

	always_ff @(posedge clk) begin
		if (rdy[13]) begin
			if (rnd > 26'sd32767)
				m_axis_tdata <= 16'h7FFF;
			else if (rnd < -26'sd32768)
				m_axis_tdata <= 16'h8000;
			else
				m_axis_tdata <= rnd[15:0];
		end
	end

endmodule
